// File: rtl/fcca_pkg.sv
// Shared types, constants and entry decoding functions for the FAT cluster
// chain allocator. It has no dependencies and is compiled first.
package fcca_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_ALLOC = 2'd2;

   localparam logic CSR_FAT_KIND    = 1'b0;
   localparam logic CSR_ENTRY_COUNT = 1'b1;

   localparam logic FAT_16 = 1'b0;

   localparam logic [2:0] KIND_PTR  = 3'd0;
   localparam logic [2:0] KIND_EOC  = 3'd1;
   localparam logic [2:0] KIND_FREE = 3'd2;
   localparam logic [2:0] KIND_BAD  = 3'd3;
   localparam logic [2:0] KIND_RSVD = 3'd4;

   localparam logic [27:0] EOC_VALUE      = 28'hFFFFFFF;
   localparam logic [27:0] PTR_MAX        = 28'hFFFFFEF;
   localparam logic [27:0] EOC_MIN        = 28'hFFFFFF8;
   localparam logic [27:0] BAD_VALUE      = 28'hFFFFFF7;
   localparam logic [15:0] F16_WIDEN_MIN  = 16'hFFF7;
   localparam logic [27:0] F16_WIDEN_BITS = 28'hFFF0000;
   localparam logic [16:0] FIRST_DATA     = 17'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_SCAN_ISSUE,
      ST_SCAN_CHECK,
      ST_LINK_READ,
      ST_LINK_WRITE,
      ST_DONE
   } state_type;

   function automatic logic [27:0] entry_value(input logic [31:0] word, input logic fat_kind);
      logic [27:0] v;
      if (fat_kind == FAT_16) begin
         if (word[15:0] < F16_WIDEN_MIN) begin
            v = {12'd0, word[15:0]};
         end else begin
            v = F16_WIDEN_BITS | {12'd0, word[15:0]};
         end
      end else begin
         v = word[27:0];
      end
      return v;
   endfunction

   function automatic logic [2:0] classify(input logic [27:0] v);
      logic [2:0] k;
      if (v <= PTR_MAX && v > 28'd1) begin
         k = KIND_PTR;
      end else if (v == 28'd0) begin
         k = KIND_FREE;
      end else if (v >= EOC_MIN) begin
         k = KIND_EOC;
      end else if (v == BAD_VALUE) begin
         k = KIND_BAD;
      end else begin
         k = KIND_RSVD;
      end
      return k;
   endfunction

   function automatic logic is_free(input logic [31:0] word, input logic fat_kind);
      return (fat_kind == FAT_16) ? (word[15:0] == 16'd0) : (word[27:0] == 28'd0);
   endfunction

   function automatic logic [31:0] merge_value(input logic [31:0] old, input logic [27:0] v,
                                               input logic fat_kind);
      return (fat_kind == FAT_16) ? {old[31:16], v[15:0]} : {old[31:28], v};
   endfunction

endpackage

// File: rtl/fcca_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
module fcca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fat_cluster_chain_allocator.sv
// Top level of the FAT cluster chain allocator: sequencer, registers and table.
// Depends on fcca_pkg and fcca_ram.
//
// One word is taken at a time; req_ready is high only while the sequencer is idle.
// All table traffic goes through the single read port and single write port of
// one RAM with a registered read, and that port sets the timing: a load or a failed
// request goes from the execute state straight to the result state, a read passes a
// read-wait state, and an allocate scans entries from the hint (each scan step is
// one RAM read and one check), marks the free entry end of chain, then reads and
// rewrites the requesting entry to point at it. An allocate that finds none free
// answers once the scan reaches the entry count. The block is ready again as the
// result word is registered, later while the previous result word is still held.
// The table needs no clearing after reset, so the block is ready straight away.
module fat_cluster_chain_allocator #(
   parameter int TABLE_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_cluster_index,
   input  logic [31:0] req_raw_entry,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [27:0] rsp_cluster_value,
   output logic [2:0]  rsp_cluster_kind,
   output logic        rsp_failed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int MEM_DEPTH = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;
   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [16:0] DEPTH_LIMIT = 17'(MEM_DEPTH);

   fcca_pkg::state_type state_ff, state_in;

   logic        fat_kind_ff, fat_kind_in;
   logic [16:0] entry_count_ff, entry_count_in;
   logic [15:0] hint_ff, hint_in;
   logic [16:0] scan_ff, scan_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] idx_ff, idx_in;
   logic [31:0] raw_ff, raw_in;
   logic [27:0] res_value_ff, res_value_in;
   logic [2:0]  res_kind_ff, res_kind_in;
   logic        res_failed_ff, res_failed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [27:0] rsp_value_ff, rsp_value_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_failed_ff, rsp_failed_in;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;

   logic [16:0] live_count;
   logic        idx_in_range;
   logic        scan_done;
   logic        found_free;
   logic        rsp_free;
   logic [16:0] scan_next;
   logic [27:0] read_value;

   fcca_ram #(
      .WIDTH(32),
      .DEPTH(MEM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign live_count   = (entry_count_ff > DEPTH_LIMIT) ? DEPTH_LIMIT : entry_count_ff;
   assign idx_in_range = {1'b0, idx_ff} < live_count;
   assign scan_done    = scan_ff >= live_count;
   assign found_free   = fcca_pkg::is_free(mem_rd_data, fat_kind_ff);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign scan_next    = scan_ff + 17'd1;
   assign read_value   = fcca_pkg::entry_value(mem_rd_data, fat_kind_ff);

   assign req_ready = (state_ff == fcca_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcca_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fcca_pkg::ST_EXEC;
            end
         end
         fcca_pkg::ST_EXEC: begin
            if (idx_in_range && op_ff == fcca_pkg::OP_READ) begin
               state_in = fcca_pkg::ST_READ_WAIT;
            end else if (idx_in_range && op_ff == fcca_pkg::OP_ALLOC) begin
               state_in = fcca_pkg::ST_SCAN_ISSUE;
            end else begin
               state_in = fcca_pkg::ST_DONE;
            end
         end
         fcca_pkg::ST_READ_WAIT: state_in = fcca_pkg::ST_DONE;
         fcca_pkg::ST_SCAN_ISSUE: begin
            state_in = scan_done ? fcca_pkg::ST_DONE : fcca_pkg::ST_SCAN_CHECK;
         end
         fcca_pkg::ST_SCAN_CHECK: begin
            state_in = found_free ? fcca_pkg::ST_LINK_READ : fcca_pkg::ST_SCAN_ISSUE;
         end
         fcca_pkg::ST_LINK_READ:  state_in = fcca_pkg::ST_LINK_WRITE;
         fcca_pkg::ST_LINK_WRITE: state_in = fcca_pkg::ST_DONE;
         fcca_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = fcca_pkg::ST_IDLE;
            end
         end
         default: state_in = fcca_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff[AW-1:0];
      mem_wr_data   = raw_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff[AW-1:0];
      hint_in       = hint_ff;
      scan_in       = scan_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      raw_in        = raw_ff;
      res_value_in  = res_value_ff;
      res_kind_in   = res_kind_ff;
      res_failed_in = res_failed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_failed_in = rsp_failed_ff;
      case (state_ff)
         fcca_pkg::ST_IDLE: begin
            op_in  = req_opcode;
            idx_in = req_cluster_index;
            raw_in = req_raw_entry;
         end
         fcca_pkg::ST_EXEC: begin
            res_value_in  = 28'd0;
            res_kind_in   = fcca_pkg::KIND_PTR;
            res_failed_in = 1'b1;
            if ({1'b0, hint_ff} > fcca_pkg::FIRST_DATA) begin
               scan_in = {1'b0, hint_ff};
            end else begin
               scan_in = fcca_pkg::FIRST_DATA;
            end
            if (idx_in_range && op_ff == fcca_pkg::OP_LOAD) begin
               mem_wr_en     = 1'b1;
               res_failed_in = 1'b0;
            end
            if (idx_in_range && op_ff == fcca_pkg::OP_READ) begin
               mem_rd_en = 1'b1;
            end
         end
         fcca_pkg::ST_READ_WAIT: begin
            res_value_in  = read_value;
            res_kind_in   = fcca_pkg::classify(read_value);
            res_failed_in = 1'b0;
         end
         fcca_pkg::ST_SCAN_ISSUE: begin
            mem_rd_en   = !scan_done;
            mem_rd_addr = scan_ff[AW-1:0];
         end
         fcca_pkg::ST_SCAN_CHECK: begin
            mem_wr_addr = scan_ff[AW-1:0];
            mem_wr_data = fcca_pkg::merge_value(mem_rd_data, fcca_pkg::EOC_VALUE, fat_kind_ff);
            if (found_free) begin
               mem_wr_en    = 1'b1;
               res_value_in = 28'(scan_ff);
               if (scan_next >= live_count) begin
                  hint_in = 16'(fcca_pkg::FIRST_DATA);
               end else begin
                  hint_in = scan_next[15:0];
               end
            end else begin
               scan_in = scan_next;
            end
         end
         fcca_pkg::ST_LINK_READ: begin
            mem_rd_en = 1'b1;
         end
         fcca_pkg::ST_LINK_WRITE: begin
            mem_wr_en     = 1'b1;
            mem_wr_data   = fcca_pkg::merge_value(mem_rd_data, 28'(scan_ff), fat_kind_ff);
            res_failed_in = 1'b0;
         end
         fcca_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_failed_in = res_failed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      fat_kind_in    = fat_kind_ff;
      entry_count_in = entry_count_ff;
      if (csr_valid && csr_index == fcca_pkg::CSR_FAT_KIND) begin
         fat_kind_in = csr_wdata[0];
      end
      if (csr_valid && csr_index == fcca_pkg::CSR_ENTRY_COUNT) begin
         entry_count_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fcca_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         fat_kind_ff    <= 1'b1;
         entry_count_ff <= 17'h10000;
         hint_ff        <= 16'(fcca_pkg::FIRST_DATA);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         fat_kind_ff    <= fat_kind_in;
         entry_count_ff <= entry_count_in;
         hint_ff        <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      raw_ff        <= raw_in;
      res_value_ff  <= res_value_in;
      res_kind_ff   <= res_kind_in;
      res_failed_ff <= res_failed_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cluster_value = rsp_value_ff;
   assign rsp_cluster_kind  = rsp_kind_ff;
   assign rsp_failed        = rsp_failed_ff;

endmodule

// File: rtl/fcca_checker.sv
// Port-level checks for the FAT cluster chain allocator, bound to its top level.
// Depends on fcca_pkg and fat_cluster_chain_allocator.
module fcca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [27:0] rsp_cluster_value,
   input logic [2:0]  rsp_cluster_kind,
   input logic        rsp_failed
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("A result word is shown straight after reset.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A new request word is taken while one is still in work.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_cluster_value == 28'd0
                                  && rsp_cluster_kind == fcca_pkg::KIND_PTR)
      else $error("A failed result word carries a value or a class.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cluster_value)
                                  && $stable(rsp_cluster_kind) && $stable(rsp_failed))
      else $error("A stalled result word changed.");

endmodule

bind fat_cluster_chain_allocator fcca_checker u_fcca_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_cluster_value (rsp_cluster_value),
   .rsp_cluster_kind  (rsp_cluster_kind),
   .rsp_failed        (rsp_failed)
);

// File: bench/tb_fat_cluster_chain_allocator.sv
`timescale 1ns / 1ps
// Self-checking bench for fat_cluster_chain_allocator: a scripted opening, then randomised
// phases of loads, reads and allocations checked against a behavioural model of the table.
// Depends on fcca_pkg and the allocator RTL; it reads no files.
module tb_fat_cluster_chain_allocator;

   typedef struct packed {
      logic [27:0] value;
      logic [2:0]  kind;
      logic        failed;
   } chain_answer_type;

   typedef struct packed {
      logic             is_cfg;
      logic             csr_sel;
      logic [16:0]      csr_data;
      logic [1:0]       op;
      logic [15:0]      idx;
      logic [31:0]      raw;
      logic             typed;
      chain_answer_type ans;
   } script_row_type;

   localparam logic [1:0] OP_BAD = 2'd3;
   localparam logic FAT_32 = ~fcca_pkg::FAT_16;
   localparam logic IS_ITEM = 1'b0;
   localparam logic IS_CFG = 1'b1;
   localparam logic PREDICT = 1'b0;
   localparam logic TYPED = 1'b1;
   localparam chain_answer_type NO_ANSWER = '0;
   localparam int FULL_TABLE = 65536;
   localparam int HOT_SPAN = 256;
   localparam int STEP_ROWS = 28;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 93;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [15:0] req_cluster_index;
   logic [31:0] req_raw_entry;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [27:0] rsp_cluster_value;
   logic [2:0]  rsp_cluster_kind;
   logic        rsp_failed;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [16:0] csr_wdata;

   logic [31:0]      fat_words [FULL_TABLE];
   bit               fat_known [FULL_TABLE];
   int               known_list [$];
   bit               fat16_mode;
   int               live_entries;
   int               free_hint;
   chain_answer_type answers_due [$];
   int               mismatch_count = 0;
   bit               quiet_mode = 1'b0;
   int               sink_hold = 0;

   script_row_type steps [STEP_ROWS] = '{
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd0, 32'hFFFF_FFFF,
        TYPED, '{28'h0, fcca_pkg::KIND_PTR, 1'b0}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'hFFFF, 32'h0,
        TYPED, '{28'h0, fcca_pkg::KIND_PTR, 1'b0}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'hFFFF, 32'h0,
        TYPED, '{28'h0, fcca_pkg::KIND_FREE, 1'b0}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd0, 32'h0,
        TYPED, '{28'hFFFFFFF, fcca_pkg::KIND_EOC, 1'b0}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, OP_BAD, 16'h1234, 32'hFFFF_FFFF,
        TYPED, '{28'h0, fcca_pkg::KIND_PTR, 1'b1}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd2, 32'hF000_0000,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_ALLOC, 16'd0, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd2, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd0, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd3, 32'h0FFF_FFF7,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd3, 32'h0,
        TYPED, '{28'hFFFFFF7, fcca_pkg::KIND_BAD, 1'b0}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd4, 32'h0000_0001,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd4, 32'h0,
        TYPED, '{28'h1, fcca_pkg::KIND_RSVD, 1'b0}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd5, 32'h0FFF_FFF0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd5, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd6, 32'hAFFF_FFEF,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd6, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd7, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_ALLOC, 16'd7, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd7, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_CFG, fcca_pkg::CSR_ENTRY_COUNT, 17'd8, fcca_pkg::OP_LOAD, 16'd0, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_ALLOC, 16'd8, 32'h0,
        TYPED, '{28'h0, fcca_pkg::KIND_PTR, 1'b1}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'hFFFF, 32'h1234_5678,
        TYPED, '{28'h0, fcca_pkg::KIND_PTR, 1'b1}},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_ALLOC, 16'd0, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_CFG, fcca_pkg::CSR_FAT_KIND, {16'd0, fcca_pkg::FAT_16}, fcca_pkg::OP_LOAD, 16'd0,
        32'h0, PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd2, 32'h0,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_LOAD, 16'd1, 32'h1234_FFF7,
        PREDICT, NO_ANSWER},
      '{IS_ITEM, fcca_pkg::CSR_FAT_KIND, 17'd0, fcca_pkg::OP_READ, 16'd1, 32'h0,
        PREDICT, NO_ANSWER}
   };

   fat_cluster_chain_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_cluster_index (req_cluster_index),
      .req_raw_entry     (req_raw_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cluster_value (rsp_cluster_value),
      .rsp_cluster_kind  (rsp_cluster_kind),
      .rsp_failed        (rsp_failed),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [27:0] next_cluster_of(input logic [31:0] w);
      if (!fat16_mode) begin
         return w[27:0];
      end
      if (w[15:0] >= fcca_pkg::F16_WIDEN_MIN) begin
         return fcca_pkg::F16_WIDEN_BITS | {12'd0, w[15:0]};
      end
      return {12'd0, w[15:0]};
   endfunction

   function automatic logic [2:0] kind_of(input logic [27:0] v);
      if (v == 28'd0) begin
         return fcca_pkg::KIND_FREE;
      end else if (v == 28'd1) begin
         return fcca_pkg::KIND_RSVD;
      end else if (v <= fcca_pkg::PTR_MAX) begin
         return fcca_pkg::KIND_PTR;
      end else if (v >= fcca_pkg::EOC_MIN) begin
         return fcca_pkg::KIND_EOC;
      end else if (v == fcca_pkg::BAD_VALUE) begin
         return fcca_pkg::KIND_BAD;
      end
      return fcca_pkg::KIND_RSVD;
   endfunction

   function automatic logic [31:0] with_next(input logic [31:0] old, input logic [27:0] v);
      return fat16_mode ? {old[31:16], v[15:0]} : {old[31:28], v};
   endfunction

   function automatic void model_fat_op(input logic [1:0] op, input logic [15:0] idx,
                                        input logic [31:0] raw, output chain_answer_type a);
      int c;
      int i;
      a = '{value: 28'd0, kind: fcca_pkg::KIND_PTR, failed: 1'b1};
      i = idx;
      if (i < live_entries) begin
         case (op)
            fcca_pkg::OP_LOAD: begin
               fat_words[i] = raw;
               if (!fat_known[i]) begin
                  fat_known[i] = 1'b1;
                  known_list.insert(known_list.size(), i);
               end
               a.failed = 1'b0;
            end
            fcca_pkg::OP_READ: begin
               a.value = next_cluster_of(fat_words[i]);
               a.kind = kind_of(a.value);
               a.failed = 1'b0;
            end
            fcca_pkg::OP_ALLOC: begin
               c = (free_hint > int'(fcca_pkg::FIRST_DATA)) ? free_hint
                                                             : int'(fcca_pkg::FIRST_DATA);
               for (; c < live_entries; c++) begin
                  if (next_cluster_of(fat_words[c]) == 28'd0) begin
                     fat_words[c] = with_next(fat_words[c], fcca_pkg::EOC_VALUE);
                     free_hint = (c + 1 >= live_entries) ? int'(fcca_pkg::FIRST_DATA) : c + 1;
                     fat_words[i] = with_next(fat_words[i], 28'(c));
                     a.value = 28'(c);
                     a.failed = 1'b0;
                     break;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   endfunction

   function automatic int idle_gap();
      int r;
      if (quiet_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int hot_span();
      return (live_entries < HOT_SPAN) ? live_entries : HOT_SPAN;
   endfunction

   function automatic bit pick_known(output logic [15:0] idx);
      int c;
      idx = '0;
      for (int t = 0; t < 8; t++) begin
         if ($urandom_range(0, 1) == 1 && known_list.size() != 0) begin
            c = known_list[$urandom_range(0, known_list.size() - 1)];
         end else begin
            c = $urandom_range(0, hot_span() - 1);
         end
         if (c < live_entries && fat_known[c]) begin
            idx = 16'(c);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [15:0] load_target();
      int q;
      q = $urandom_range(0, 9);
      if (q < 4 && known_list.size() != 0) begin
         return 16'(known_list[$urandom_range(0, known_list.size() - 1)]);
      end else if (q < 8) begin
         return 16'($urandom_range(0, hot_span() - 1));
      end
      return 16'($urandom_range(0, live_entries - 1));
   endfunction

   function automatic logic [31:0] pick_raw(input int free_pct);
      logic [27:0] odd [8];
      logic [31:0] w;
      int r;
      odd = '{28'hFFFFFF7, 28'hFFFFFF8, 28'hFFFFFFF, 28'h0000001,
              28'hFFFFFEF, 28'hFFFFFF0, 28'h000FFF6, 28'h0000002};
      w = $urandom;
      r = $urandom_range(0, 99);
      if (r < free_pct) begin
         if (fat16_mode) begin
            w[15:0] = '0;
         end else begin
            w[27:0] = '0;
         end
      end else if (r < free_pct + 25) begin
         w[27:0] = odd[$urandom_range(0, 7)];
      end
      return w;
   endfunction

   // An allocation may only scan entries that have been written since reset.
   function automatic int first_unknown_on_scan();
      int c;
      c = (free_hint > int'(fcca_pkg::FIRST_DATA)) ? free_hint : int'(fcca_pkg::FIRST_DATA);
      for (; c < live_entries; c++) begin
         if (!fat_known[c]) begin
            return c;
         end
         if (next_cluster_of(fat_words[c]) == 28'd0) begin
            return -1;
         end
      end
      return -1;
   endfunction

   task automatic issue(input logic [1:0] op, input logic [15:0] idx, input logic [31:0] raw,
                        input logic typed, input chain_answer_type given);
      chain_answer_type predicted;
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_cluster_index <= idx;
      req_raw_entry <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_fat_op(op, idx, raw, predicted);
      answers_due.insert(answers_due.size(), typed ? given : predicted);
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic sel, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (sel == fcca_pkg::CSR_FAT_KIND) begin
         fat16_mode = (data[0] == fcca_pkg::FAT_16);
      end else begin
         live_entries = (data > FULL_TABLE) ? FULL_TABLE : int'(data);
      end
   endtask

   task automatic random_item();
      logic [15:0] idx;
      int r;
      int hole;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         issue(OP_BAD, 16'($urandom), $urandom, PREDICT, NO_ANSWER);
      end else if (r < 11 && live_entries < FULL_TABLE) begin
         issue(2'($urandom_range(0, 2)), 16'($urandom_range(live_entries, FULL_TABLE - 1)),
               $urandom, PREDICT, NO_ANSWER);
      end else if (r < 42) begin
         issue(fcca_pkg::OP_LOAD, load_target(), pick_raw(40), PREDICT, NO_ANSWER);
      end else if (!pick_known(idx)) begin
         issue(fcca_pkg::OP_LOAD, 16'($urandom_range(0, hot_span() - 1)), pick_raw(40),
               PREDICT, NO_ANSWER);
      end else if (r < 68) begin
         issue(fcca_pkg::OP_READ, idx, $urandom, PREDICT, NO_ANSWER);
      end else begin
         hole = first_unknown_on_scan();
         if (hole >= 0) begin
            issue(fcca_pkg::OP_LOAD, 16'(hole), pick_raw(60), PREDICT, NO_ANSWER);
         end else begin
            issue(fcca_pkg::OP_ALLOC, idx, $urandom, PREDICT, NO_ANSWER);
         end
      end
   endtask

   always @(posedge clock) begin : sink_pacing
      int gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_hold <= 0;
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
      end else if (quiet_mode || !rsp_ready) begin
         rsp_ready <= 1'b1;
         sink_hold <= quiet_mode ? 0 : $urandom_range(0, 6);
      end else begin
         gap = idle_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            sink_hold <= gap - 1;
         end else begin
            sink_hold <= $urandom_range(0, 4);
         end
      end
   end

   always @(posedge clock) begin : answer_check
      chain_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected word, value %h kind %0d failed %0d", $time,
                     rsp_cluster_value, rsp_cluster_kind, rsp_failed);
            mismatch_count++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_cluster_value !== want.value) begin
               $display("%0t: cluster_value expected %h actual %h", $time, want.value,
                        rsp_cluster_value);
               mismatch_count++;
            end
            if (rsp_cluster_kind !== want.kind) begin
               $display("%0t: cluster_kind expected %0d actual %0d", $time, want.kind,
                        rsp_cluster_kind);
               mismatch_count++;
            end
            if (rsp_failed !== want.failed) begin
               $display("%0t: failed expected %0d actual %0d", $time, want.failed,
                        rsp_failed);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int phase_count [PHASES];
      logic phase_fat [PHASES];
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = fcca_pkg::OP_LOAD;
      req_cluster_index = '0;
      req_raw_entry = '0;
      csr_valid = 1'b0;
      csr_index = fcca_pkg::CSR_FAT_KIND;
      csr_wdata = '0;
      fat16_mode = 1'b0;
      live_entries = FULL_TABLE;
      free_hint = int'(fcca_pkg::FIRST_DATA);
      for (int p = 0; p < PHASES; p++) begin
         phase_fat[p] = $urandom_range(0, 1) ? FAT_32 : fcca_pkg::FAT_16;
         phase_count[p] = $urandom_range(0, 1) ? $urandom_range(3, 40)
                                               : $urandom_range(41, 700);
      end
      phase_fat[0] = fcca_pkg::FAT_16;
      phase_count[0] = 3;
      phase_fat[1] = FAT_32;
      phase_count[1] = FULL_TABLE;
      phase_fat[2] = fcca_pkg::FAT_16;
      phase_count[2] = FULL_TABLE;
      phase_fat[3] = FAT_32;
      phase_count[3] = 3;
      phase_count[4] = FULL_TABLE - 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (steps[i]) begin
         if (steps[i].is_cfg) begin
            drain();
            write_csr(steps[i].csr_sel, steps[i].csr_data);
            csr_valid <= 1'b0;
         end else begin
            issue(steps[i].op, steps[i].idx, steps[i].raw, steps[i].typed, steps[i].ans);
         end
      end
      for (int p = 0; p < PHASES; p++) begin
         drain();
         quiet_mode = (p == 3 || p == 7);
         write_csr(fcca_pkg::CSR_FAT_KIND, {16'd0, phase_fat[p]});
         write_csr(fcca_pkg::CSR_ENTRY_COUNT, 17'(phase_count[p]));
         csr_valid <= 1'b0;
         repeat (PHASE_ITEMS) random_item();
      end
      drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
